@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with an active-low asynchronous reset as disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same check, but on the rising clock edge and with no reset disable.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/aopb_pkg.sv @@
// Types, constants and helpers for the alpha-over pixel blender.
// No dependencies; imported by alpha_over_pixel_blend_top.
package aopb_pkg;

	localparam int CHAN_W   = 8;
	localparam int WIDE_W   = 16;
	localparam int ACC_W    = 24;
	localparam int NCHAN    = 3;
	localparam int DIV_BITS = 8;
	localparam int NSTAGE   = 5 + DIV_BITS;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [ACC_W-1:0]  acc_t;

	localparam chan_t CH_MAX  = 8'd255;
	localparam chan_t CH_HALF = 8'd127;

	typedef struct packed {
		chan_t [NCHAN-1:0] src;
		chan_t [NCHAN-1:0] dst;
		chan_t             da;
		wide_t             p;
	} s1_t;

	typedef struct packed {
		chan_t [NCHAN-1:0] src;
		chan_t [NCHAN-1:0] dst;
		chan_t             da;
		chan_t             sa;
		chan_t             inv;
	} s2_t;

	typedef struct packed {
		chan_t [NCHAN-1:0] src;
		chan_t [NCHAN-1:0] dst;
		wide_t             sw;
		wide_t             dw;
	} s3_t;

	typedef struct packed {
		acc_t [NCHAN-1:0] ps;
		acc_t [NCHAN-1:0] pd;
		wide_t            num;
	} s4_t;

	typedef struct packed {
		acc_t [NCHAN-1:0] acc;
		wide_t            num;
		chan_t            alpha;
		logic             zero;
	} s5_t;

	typedef struct packed {
		acc_t  [NCHAN-1:0] rem;
		chan_t [NCHAN-1:0] quot;
		wide_t             num;
		chan_t             alpha;
		logic              zero;
	} dv_t;

	// x / 255 for x below 65280, as shift-add
	function automatic chan_t div255(logic [WIDE_W:0] x);
		logic [WIDE_W:0] t;
		t = x + (WIDE_W+1)'(x[WIDE_W:CHAN_W]) + (WIDE_W+1)'(1);
		return t[WIDE_W-1:CHAN_W];
	endfunction

endpackage

@@ rtl/alpha_over_pixel_blend_top.sv @@
// Straight-alpha RGBA8 source-over-destination blender, top level.
// Depends on aopb_pkg and assert_macros.svh.
//
// One pixel pair per cycle sustained while the output is not stalled.
// Stages 1-5 scale the source alpha by global_alpha, form the weights and the
// output alpha; stages 6-13 are a restoring divider that resolves one quotient
// bit per stage for all three colour channels at once. Each stage holds its
// word while stalled and fills bubbles, so back-pressure loses nothing.
// global_alpha should be written only while the pipeline is empty.
`include "assert_macros.svh"

module alpha_over_pixel_blend_top
	import aopb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        global_alpha_we,
	input  logic [7:0]  global_alpha_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// src_red, src_green, src_blue, src_opacity, dst_red, dst_green, dst_blue, dst_opacity
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_red, out_green, out_blue, out_opacity
	output logic [31:0] m_axis_tdata
);

	chan_t              ga_q;
	logic [NSTAGE-1:0]  vld_s;
	logic [NSTAGE-1:0]  rdy;
	s1_t                blk_s1;
	s2_t                blk_s2;
	s3_t                blk_s3;
	s4_t                blk_s4;
	s5_t                blk_s5;
	dv_t                dv_s [DIV_BITS];
	dv_t                dv_in [DIV_BITS];
	dv_t                dv_nxt [DIV_BITS];
	chan_t [NCHAN-1:0]  out_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q <= CH_MAX;
		end else if (global_alpha_we) begin
			ga_q <= global_alpha_wdata;
		end
	end

	// per-stage ready: a stage loads when empty or when its word moves on
	always_comb begin
		rdy[NSTAGE-1] = !vld_s[NSTAGE-1] || m_axis_tready;
		for (int k = NSTAGE-2; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign s_axis_tready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: unpack, source alpha times global alpha
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int c = 0; c < NCHAN; c++) begin
				blk_s1.src[c] <= s_axis_tdata[c*CHAN_W +: CHAN_W];
				blk_s1.dst[c] <= s_axis_tdata[(c+4)*CHAN_W +: CHAN_W];
			end
			blk_s1.da <= s_axis_tdata[7*CHAN_W +: CHAN_W];
			blk_s1.p  <= WIDE_W'(s_axis_tdata[3*CHAN_W +: CHAN_W]) * WIDE_W'(ga_q);
		end
	end

	// stage 2: scaled source alpha and its complement
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			blk_s2.src <= blk_s1.src;
			blk_s2.dst <= blk_s1.dst;
			blk_s2.da  <= blk_s1.da;
			blk_s2.sa  <= div255((WIDE_W+1)'(blk_s1.p) + (WIDE_W+1)'(CH_HALF));
			blk_s2.inv <= CH_MAX - div255((WIDE_W+1)'(blk_s1.p) + (WIDE_W+1)'(CH_HALF));
		end
	end

	// stage 3: source and destination weights
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			blk_s3.src <= blk_s2.src;
			blk_s3.dst <= blk_s2.dst;
			blk_s3.sw  <= {blk_s2.sa, CHAN_W'(0)} - WIDE_W'(blk_s2.sa);
			blk_s3.dw  <= WIDE_W'(blk_s2.da) * WIDE_W'(blk_s2.inv);
		end
	end

	// stage 4: weighted channel products and alpha numerator
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int c = 0; c < NCHAN; c++) begin
				blk_s4.ps[c] <= ACC_W'(blk_s3.src[c]) * ACC_W'(blk_s3.sw);
				blk_s4.pd[c] <= ACC_W'(blk_s3.dst[c]) * ACC_W'(blk_s3.dw);
			end
			blk_s4.num <= blk_s3.sw + blk_s3.dw;
		end
	end

	// stage 5: rounded dividends, output alpha
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int c = 0; c < NCHAN; c++) begin
				blk_s5.acc[c] <= blk_s4.ps[c] + blk_s4.pd[c] + ACC_W'(blk_s4.num >> 1);
			end
			blk_s5.num   <= blk_s4.num;
			blk_s5.alpha <= div255((WIDE_W+1)'(blk_s4.num) + (WIDE_W+1)'(CH_HALF));
			blk_s5.zero  <= (blk_s4.num == '0);
		end
	end

	// stages 6..13: restoring divider, MSB first
	always_comb begin
		dv_in[0].rem   = blk_s5.acc;
		dv_in[0].quot  = '0;
		dv_in[0].num   = blk_s5.num;
		dv_in[0].alpha = blk_s5.alpha;
		dv_in[0].zero  = blk_s5.zero;
		for (int k = 1; k < DIV_BITS; k++) begin
			dv_in[k] = dv_s[k-1];
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		localparam int BIT = DIV_BITS - 1 - k;

		always_comb begin
			acc_t dsr;
			dsr = ACC_W'(dv_in[k].num) << BIT;
			dv_nxt[k] = dv_in[k];
			for (int c = 0; c < NCHAN; c++) begin
				if (dv_in[k].rem[c] >= dsr) begin
					dv_nxt[k].rem[c]       = dv_in[k].rem[c] - dsr;
					dv_nxt[k].quot[c][BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[5+k]) begin
				dv_s[k] <= dv_nxt[k];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			out_c[c] = dv_s[DIV_BITS-1].zero ? '0 : dv_s[DIV_BITS-1].quot[c];
		end
	end

	assign m_axis_tvalid = vld_s[NSTAGE-1];
	assign m_axis_tdata  = {dv_s[DIV_BITS-1].alpha, out_c[2], out_c[1], out_c[0]};

	`ASSERT_CLK(a_div_rem_bound, clk, arst_n,
		vld_s[NSTAGE-1] && !dv_s[DIV_BITS-1].zero |->
			(dv_s[DIV_BITS-1].rem[0] < ACC_W'(dv_s[DIV_BITS-1].num)) &&
			(dv_s[DIV_BITS-1].rem[1] < ACC_W'(dv_s[DIV_BITS-1].num)) &&
			(dv_s[DIV_BITS-1].rem[2] < ACC_W'(dv_s[DIV_BITS-1].num)),
		"divider remainder not below divisor")
	`ASSERT_CLK(a_stall_only_full, clk, arst_n, !s_axis_tready |-> (&vld_s),
		"input stalled while pipeline has a bubble")
	`ASSERT_CLK(a_alpha_nonzero, clk, arst_n,
		vld_s[NSTAGE-1] && !dv_s[DIV_BITS-1].zero |-> dv_s[DIV_BITS-1].alpha != '0,
		"nonzero numerator gave zero alpha")

endmodule
